// ===== design/smau_pkg.sv =====
// ----------------------------------------------------------------------------
// smau_pkg: shared types and constants
// Operation codes, register widths and the controller/datapath command struct.
// ----------------------------------------------------------------------------
package smau_pkg;

  localparam int AccW = 38;
  localparam int WordW = 36;
  localparam int MagW = 35;
  localparam int ActW = 4;
  localparam int CntW = 8;
  // Multiply and divide step count.
  localparam logic [CntW-1:0] Steps = 8'd35;

  typedef enum logic [ActW-1:0] {
    ACT_RND = 4'd0, ACT_RADD = 4'd1, ACT_RSUB = 4'd2, ACT_LDMQ = 4'd3,
    ACT_ADD = 4'd4, ACT_SUB = 4'd5, ACT_ADDAB = 4'd6, ACT_SUBAB = 4'd7,
    ACT_MPY = 4'd8, ACT_MPYR = 4'd9, ACT_DIV = 4'd10, ACT_LLEFT = 4'd11,
    ACT_LRIGHT = 4'd12, ACT_ALEFT = 4'd13, ACT_ARIGHT = 4'd14, ACT_TESTOVF = 4'd15
  } action_t;

  typedef struct packed {
    logic                 load;   // capture request, run non-loop ops, set up loops
    logic                 step;   // one iteration of the current loop
    logic                 finish; // final fixup of a loop op
  } dp_cmd_t;

  typedef struct packed {
    logic loop_op;   // captured op needs iterations
    logic last_step; // counter reaches zero after this step
  } dp_status_t;

  typedef struct packed {
    logic [ActW-1:0]  action;
    logic [WordW-1:0] operand;
    logic [CntW-1:0]  shift_count;
  } in_item_t;

  typedef struct packed {
    logic [AccW-1:0]  acc_value;
    logic [WordW-1:0] mq_value;
    logic             overflow_now;
    logic             overflow_seen;
    logic             divide_check;
    logic             acc_zero;
    logic             acc_plus;
    logic [WordW-1:0] store_word;
  } out_item_t;

endpackage

// ===== design/smau_if.sv =====
// ----------------------------------------------------------------------------
// smau_in_if / smau_out_if: valid-ready channels
// One request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface smau_in_if;
  logic                valid;
  logic                ready;
  smau_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface smau_out_if;
  logic                valid;
  logic                ready;
  smau_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/smau_ctrl.sv =====
// ----------------------------------------------------------------------------
// smau_ctrl: sequencing state machine
// Accepts a request, runs loop steps, and holds the result until taken.
// ----------------------------------------------------------------------------
module smau_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  smau_pkg::dp_status_t   status,
  output smau_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_RUN = 3'b010, ST_FIN = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_valid_q;

  // The next request may enter once the output slot is free or being emptied.
  assign in_ready  = (state == ST_IDLE) && (!out_valid_q || out_ready);
  assign out_valid = out_valid_q;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid_q && !out_ready;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          if (status.loop_op) begin
            state_next = ST_RUN;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish     = 1'b1;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      out_valid_q <= out_valid_next;
    end
  end

endmodule

// ===== design/smau_dp.sv =====
// ----------------------------------------------------------------------------
// smau_dp: accumulator, MQ and flag datapath
// Non-loop ops finish on load; multiply, divide and loop shifts, one step a cycle.
// ----------------------------------------------------------------------------
module smau_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  smau_pkg::in_item_t    item,
  input  smau_pkg::dp_cmd_t     cmd,
  output smau_pkg::dp_status_t  status,
  output smau_pkg::out_item_t   result
);

  localparam int AccW = smau_pkg::AccW;
  localparam int WordW = smau_pkg::WordW;
  localparam int MagW = smau_pkg::MagW;

  logic [AccW-1:0]  acc;
  logic [WordW-1:0] mq;
  logic             ovf;
  logic             dchk;
  logic             seen;
  logic [smau_pkg::ActW-1:0]  op;
  logic [MagW-1:0]  opnd;     // multiplicand or divisor magnitude
  logic             sgn;      // sign to apply at finish
  logic             qsgn;     // quotient/product sign
  logic [smau_pkg::CntW-1:0]  cnt;

  smau_pkg::action_t act;
  logic [AccW-1:0]  acc_next;
  logic [WordW-1:0] mq_next;
  logic             ovf_next, dchk_next, loop_next;
  logic [smau_pkg::CntW-1:0] cnt_init;

  // Sign-magnitude add on the 37-bit Q,P,magnitude field.
  logic [WordW-1:0] add_sr;
  logic             a_neg, differ;
  logic [AccW-1:0]  a_sum;
  logic [AccW-2:0]  a_inc;
  logic [AccW-1:0]  add_res;
  logic             add_ovf;

  // Step logic.
  logic [AccW-1:0]  ms_sum;
  logic [AccW-2:0]  dv_sh;
  logic [WordW-1:0] dv_mq;
  logic             dv_ge;

  assign act = smau_pkg::action_t'(item.action);

  always_comb begin
    unique case (act)
      smau_pkg::ACT_SUB:   add_sr = item.operand ^ {1'b1, {MagW{1'b0}}};
      smau_pkg::ACT_ADDAB: add_sr = {1'b0, item.operand[MagW-1:0]};
      smau_pkg::ACT_SUBAB: add_sr = {1'b1, item.operand[MagW-1:0]};
      default:             add_sr = item.operand;
    endcase
    a_neg   = acc[AccW-1];
    differ  = add_sr[WordW-1] != a_neg;
    a_sum   = {1'b0, (differ ? ~acc[AccW-2:0] : acc[AccW-2:0])}
              + {3'b0, add_sr[MagW-1:0]};
    a_inc   = a_sum[AccW-2:0] + 1'b1;
    add_ovf = 1'b0;
    if (differ) begin
      if (a_sum[AccW-1]) begin
        add_res = {!a_neg, a_inc};
        add_ovf = a_inc[MagW] != acc[MagW];
      end else begin
        add_res = {a_neg, ~a_sum[AccW-2:0]};
      end
    end else begin
      add_res = {a_neg, a_sum[AccW-2:0]};
      add_ovf = a_sum[MagW] != acc[MagW];
    end
  end

  // Non-loop operations and loop setup.
  always_comb begin
    acc_next  = acc;
    mq_next   = mq;
    ovf_next  = ovf;
    dchk_next = dchk;
    loop_next = 1'b0;
    cnt_init  = smau_pkg::Steps;
    unique case (act)
      smau_pkg::ACT_RND: if (mq[MagW-1]) acc_next = acc + 1'b1;
      smau_pkg::ACT_RADD:
        acc_next = {item.operand[WordW-1], 2'b00, item.operand[MagW-1:0]};
      smau_pkg::ACT_RSUB:
        acc_next = {!item.operand[WordW-1], 2'b00, item.operand[MagW-1:0]};
      smau_pkg::ACT_LDMQ: mq_next = item.operand;
      smau_pkg::ACT_ADD, smau_pkg::ACT_SUB, smau_pkg::ACT_ADDAB,
      smau_pkg::ACT_SUBAB: begin
        acc_next = add_res;
        ovf_next = ovf | add_ovf;
      end
      smau_pkg::ACT_MPY, smau_pkg::ACT_MPYR: begin
        acc_next = '0;
        mq_next  = {1'b0, mq[MagW-1:0]};
        if (item.operand[MagW-1:0] == '0) begin
          // A zero multiplicand clears both magnitudes but keeps the product sign.
          acc_next = {item.operand[WordW-1] ^ mq[WordW-1], {(AccW-1){1'b0}}};
          mq_next  = {item.operand[WordW-1] ^ mq[WordW-1], {MagW{1'b0}}};
        end else begin
          loop_next = 1'b1;
        end
      end
      smau_pkg::ACT_DIV: begin
        mq_next = {1'b0, mq[MagW-1:0]};
        if ({2'b00, item.operand[MagW-1:0]} <= acc[AccW-2:0]) begin
          dchk_next = 1'b1;
          mq_next   = {item.operand[WordW-1] ^ acc[AccW-1], mq[MagW-1:0]};
        end else begin
          acc_next  = {1'b0, acc[AccW-2:0]};
          loop_next = 1'b1;
        end
      end
      smau_pkg::ACT_LLEFT: begin
        acc_next  = {2'b00, acc[MagW:0]};
        loop_next = 1'b1;
        cnt_init  = item.shift_count;
      end
      smau_pkg::ACT_ALEFT: begin
        acc_next  = {acc[AccW-1], 1'b0, acc[MagW:0]};
        loop_next = 1'b1;
        cnt_init  = item.shift_count;
      end
      smau_pkg::ACT_LRIGHT: begin
        mq_next   = {1'b0, mq[MagW-1:0]};
        loop_next = 1'b1;
        cnt_init  = item.shift_count;
      end
      smau_pkg::ACT_ARIGHT: begin
        if (item.shift_count[smau_pkg::CntW-1:6] != '0) begin
          acc_next = {acc[AccW-1], {(AccW-1){1'b0}}};
        end else begin
          acc_next = {acc[AccW-1], acc[AccW-2:0] >> item.shift_count[5:0]};
        end
      end
      smau_pkg::ACT_TESTOVF: ovf_next = 1'b0;
      default: ;
    endcase
  end

  // Per-step logic of the iterative operations.
  always_comb begin
    ms_sum = acc + (mq[0] ? {3'b0, opnd} : '0);
    dv_sh  = {acc[AccW-3:0], mq[MagW-1]};
    dv_mq  = {1'b0, mq[MagW-2:0], 1'b0};
    dv_ge  = {2'b00, opnd} <= dv_sh;
  end

  assign status.loop_op   = loop_next;
  assign status.last_step = (cnt <= 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      mq   <= '0;
      ovf  <= 1'b0;
      dchk <= 1'b0;
      seen <= 1'b0;
    end else if (cmd.load) begin
      acc  <= acc_next;
      mq   <= mq_next;
      ovf  <= ovf_next;
      dchk <= dchk_next;
      seen <= ovf;
      op   <= item.action;
      opnd <= item.operand[MagW-1:0];
      cnt  <= cnt_init;
      sgn  <= (act == smau_pkg::ACT_LLEFT) ? mq[WordW-1] : acc[AccW-1];
      qsgn <= (act == smau_pkg::ACT_DIV) ? (item.operand[WordW-1] ^ acc[AccW-1])
                                        : (item.operand[WordW-1] ^ mq[WordW-1]);
    end else if (cmd.step) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        unique case (smau_pkg::action_t'(op))
          smau_pkg::ACT_MPY, smau_pkg::ACT_MPYR: begin
            mq  <= {1'b0, ms_sum[0], mq[MagW-1:1]};
            acc <= ms_sum >> 1;
          end
          smau_pkg::ACT_DIV: begin
            acc <= {1'b0, (dv_ge ? dv_sh - {2'b00, opnd} : dv_sh)};
            mq  <= {dv_mq[WordW-1:1], dv_ge};
          end
          smau_pkg::ACT_LLEFT: begin
            mq  <= {mq[WordW-2:0], 1'b0};
            acc <= {1'b0, acc[AccW-3:0], mq[WordW-2]};
            if (acc[MagW-1]) ovf <= 1'b1;
          end
          smau_pkg::ACT_ALEFT: begin
            acc <= {acc[AccW-1], acc[AccW-3:0], 1'b0};
            if (acc[MagW-1]) ovf <= 1'b1;
          end
          smau_pkg::ACT_LRIGHT: begin
            mq  <= {1'b0, acc[0], mq[MagW-1:1]};
            acc <= {acc[AccW-1], 1'b0, acc[AccW-2:1]};
          end
          default: ;
        endcase
      end
    end else if (cmd.finish) begin
      unique case (smau_pkg::action_t'(op))
        smau_pkg::ACT_MPY, smau_pkg::ACT_MPYR: begin
          acc <= {qsgn, acc[AccW-2:0] +
                  {{(AccW-2){1'b0}},
                   (op == smau_pkg::ACT_MPYR) && mq[MagW-1]}};
          mq  <= {qsgn, mq[MagW-1:0]};
        end
        smau_pkg::ACT_DIV: begin
          acc <= {sgn, acc[AccW-2:0]};
          mq  <= {qsgn, mq[MagW-1:0]};
        end
        smau_pkg::ACT_LLEFT, smau_pkg::ACT_LRIGHT: begin
          acc <= {sgn, acc[AccW-2:0]};
          mq  <= {sgn, mq[MagW-1:0]};
        end
        default: ;
      endcase
    end
  end

  assign result.acc_value     = acc;
  assign result.mq_value      = mq;
  assign result.overflow_now  = ovf;
  assign result.overflow_seen = seen;
  assign result.divide_check  = dchk;
  assign result.acc_zero      = (acc[AccW-2:0] == '0);
  assign result.acc_plus      = !acc[AccW-1];
  assign result.store_word    = {acc[AccW-1], acc[MagW-1:0]};

endmodule

// ===== design/sign_magnitude_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// sign_magnitude_accumulator_unit: accumulator and MQ arithmetic unit
// ----------------------------------------------------------------------------
// Requests enter on in_ch (action, operand, shift_count) and one result per
// request leaves on out_ch with the registers and flags after the operation.
// Round, reset add/subtract, load MQ, add/subtract forms, accumulator right
// shift and overflow test finish in the cycle of acceptance: the result is
// valid in the next cycle. Multiply and divide run 35 steps of the add/shift
// datapath followed by the finish state before the result is valid. Long
// shifts and the accumulator left shift take one step per shift position,
// and pass once through the step and finish states when the count is zero.
// Multiply by zero and divide check complete in the cycle of acceptance. One
// request is worked at a time, so operations that finish on acceptance can
// run one per cycle when the receiver keeps up.
// The result is held in the output register until taken; while it waits no
// new request is accepted, and the next one may enter in the cycle the
// result is taken. Synchronous reset clears the accumulator, MQ and the
// overflow, overflow-seen and divide check flags and drops any pending result.
// ----------------------------------------------------------------------------
module sign_magnitude_accumulator_unit (
  input  logic         clk,
  input  logic         rst,
  smau_in_if.sink      in_ch,
  smau_out_if.source   out_ch
);

  smau_pkg::dp_cmd_t    cmd;
  smau_pkg::dp_status_t status;

  smau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  smau_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch.payload),
    .cmd    (cmd),
    .status (status),
    .result (out_ch.payload)
  );

endmodule

// ===== design/smau_checker.sv =====
// ----------------------------------------------------------------------------
// smau_checker: port-level checks
// Watches the channels of the unit and its reported flags over time.
// ----------------------------------------------------------------------------
module smau_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input smau_pkg::out_item_t res
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result changed while stalled");

  // Results come one at a time: no new request while a result is stuck.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // The sign flag agrees with the store word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.acc_plus == !res.store_word[35]))
    else $error("sign flag mismatch");

  // Divide check is sticky across results.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && res.divide_check |=> res.divide_check)
    else $error("divide check cleared");

endmodule

bind sign_magnitude_accumulator_unit smau_checker u_smau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .res       (out_ch.payload)
);
